### sv/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds command, status and register codes, reset values, shared types and parameter defaults; no dependencies.
package ffea_pkg;

  localparam int DEF_FREE_DEPTH = 64;
  localparam int DEF_USED_DEPTH = 256;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam logic [1:0] CMD_BYTES   = 2'd0;
  localparam logic [1:0] CMD_PAGES   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] REG_R0_BASE = 2'd0;
  localparam logic [1:0] REG_R0_SIZE = 2'd1;
  localparam logic [1:0] REG_R1_BASE = 2'd2;
  localparam logic [1:0] REG_R1_SIZE = 2'd3;

  localparam logic [31:0] RST_R0_BASE = 32'h0180_0000;
  localparam logic [31:0] RST_R0_SIZE = 32'h0060_0000;
  localparam logic [31:0] RST_R1_BASE = 32'h01E0_0000;
  localparam logic [31:0] RST_R1_SIZE = 32'h23A0_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] size;
    logic        ovf;
    logic [31:0] address;
  } item_t;

  typedef struct packed {
    logic [31:0] r0_base;
    logic [31:0] r0_size;
    logic [31:0] r1_base;
    logic [31:0] r1_size;
  } region_t;

endpackage

### sv/ffea_front.sv
// Front end of the allocator: accepts requests, works out the rounded or page-scaled
// size and its overflow, and holds them in a two-entry queue. Depends on ffea_pkg.
module ffea_front #(
  parameter int PAGE_BYTES = ffea_pkg::DEF_PAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [31:0]         amount,
  input  logic [31:0]         address,
  output logic                q_valid,
  input  logic                q_pop,
  output ffea_pkg::item_t     q_item
);
  import ffea_pkg::*;

  localparam int PROD_W = 32 + $clog2(PAGE_BYTES) + 1;

  item_t       slots [2];
  logic        wp;
  logic        rp;
  logic [1:0]  count;
  item_t       cls;
  logic [32:0] bsum;
  logic [PROD_W-1:0] prod;
  logic        push;
  logic        pop;

  always_comb begin
    bsum = 33'(amount) + 33'd3;
    prod = PROD_W'(amount) * PROD_W'(PAGE_BYTES);
    cls.cmd = command;
    cls.address = address;
    if (command == CMD_PAGES) begin
      cls.size = prod[31:0];
      cls.ovf  = |prod[PROD_W-1:32];
    end else begin
      cls.size = {bsum[31:2], 2'b00};
      cls.ovf  = bsum[32];
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/ffea_back.sv
// Back end of the allocator: free and used extent tables and the sequencer
// that scans them, plus the result register. Depends on ffea_pkg.
module ffea_back #(
  parameter int FREE_DEPTH = ffea_pkg::DEF_FREE_DEPTH,
  parameter int USED_DEPTH = ffea_pkg::DEF_USED_DEPTH,
  parameter int PAGE_BYTES = ffea_pkg::DEF_PAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                reinit,
  input  ffea_pkg::region_t   regions,
  input  logic                q_valid,
  output logic                q_pop,
  input  ffea_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [31:0]         block_address
);
  import ffea_pkg::*;

  localparam int FW = $clog2(FREE_DEPTH);
  localparam int UW = $clog2(USED_DEPTH);
  localparam logic [FW-1:0] F_LAST = FW'(FREE_DEPTH - 1);
  localparam logic [UW-1:0] U_LAST = UW'(USED_DEPTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_USCAN = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FEV   = 4'd3;
  localparam logic [3:0] S_FAL   = 4'd4;
  localparam logic [3:0] S_FFIT  = 4'd5;
  localparam logic [3:0] S_GSCAN = 4'd6;
  localparam logic [3:0] S_GWR   = 4'd7;
  localparam logic [3:0] S_PWR   = 4'd8;
  localparam logic [3:0] S_RRD   = 4'd9;
  localparam logic [3:0] S_REV   = 4'd10;
  localparam logic [3:0] S_RFS   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [31:0] fmem_b [FREE_DEPTH];
  logic [31:0] fmem_l [FREE_DEPTH];
  logic [31:0] umem_b [USED_DEPTH];
  logic [31:0] umem_l [USED_DEPTH];
  logic [FREE_DEPTH-1:0] free_valid;
  logic [USED_DEPTH-1:0] used_valid;
  logic [1:0]  init_ovr;

  logic [3:0]    state;
  item_t         cur;
  logic [FW-1:0] fi;
  logic [FW-1:0] fj;
  logic [UW-1:0] uk;
  logic [UW-1:0] us;
  logic [31:0]   rb;
  logic [31:0]   rl;
  logic [31:0]   ub;
  logic [31:0]   ul;
  logic [32:0]   al;
  logic [32:0]   endv;
  logic [32:0]   ae;
  logic [1:0]    res_st;
  logic [31:0]   res_addr;

  logic          fw_en;
  logic [FW-1:0] fw_addr;
  logic [31:0]   fw_b;
  logic [31:0]   fw_l;
  logic          uw_en;
  logic [31:0]   uw_b;
  logic          fr_en;
  logic          ur_en;
  logic [33:0]   fit_sum;
  logic          fit;
  logic          hit;
  logic [31:0]   pw_len;

  assign fit_sum = 34'(al) + 34'(cur.size);
  assign fit     = !al[32] && (fit_sum <= 34'(endv));
  assign hit     = (ub <= cur.address) && ((33'(ub) + 33'(ul)) > 33'(cur.address));
  assign pw_len  = 32'(endv - ae);
  assign q_pop   = (state == S_IDLE);

  always_comb begin
    fw_en   = 1'b0;
    fw_addr = fi;
    fw_b    = 32'(rb + cur.size);
    fw_l    = rl - cur.size;
    uw_en   = 1'b0;
    uw_b    = rb;
    fr_en   = (state == S_FRD) && free_valid[fi];
    ur_en   = (state == S_RRD) && used_valid[uk];
    unique case (state)
      S_FEV: begin
        fw_en = (rl >= cur.size);
        uw_en = fw_en;
      end
      S_GWR: begin
        fw_en   = 1'b1;
        fw_addr = fj;
        fw_b    = rb;
        fw_l    = 32'(al - 33'(rb));
      end
      S_PWR: begin
        fw_en = 1'b1;
        fw_b  = ae[31:0];
        fw_l  = pw_len;
        uw_en = 1'b1;
        uw_b  = al[31:0];
      end
      S_RFS: begin
        fw_en   = !free_valid[fj];
        fw_addr = fj;
        fw_b    = ub;
        fw_l    = ul;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      fmem_b[fw_addr] <= fw_b;
      fmem_l[fw_addr] <= fw_l;
    end
    if (fr_en) begin
      if (fi == FW'(0) && init_ovr[0]) begin
        rb <= regions.r0_base;
        rl <= regions.r0_size;
      end else if (fi == FW'(1) && init_ovr[1]) begin
        rb <= regions.r1_base;
        rl <= regions.r1_size;
      end else begin
        rb <= fmem_b[fi];
        rl <= fmem_l[fi];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw_en) begin
      umem_b[us] <= uw_b;
      umem_l[us] <= cur.size;
    end
    if (ur_en) begin
      ub <= umem_b[uk];
      ul <= umem_l[uk];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      init_ovr <= 2'b11;
    end else if (fw_en && fw_addr == FW'(0)) begin
      init_ovr[0] <= 1'b0;
    end else if (fw_en && fw_addr == FW'(1)) begin
      init_ovr[1] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      state      <= S_IDLE;
      free_valid <= FREE_DEPTH'(2'b11);
      used_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_item;
            uk       <= '0;
            fi       <= '0;
            fj       <= '0;
            res_addr <= '0;
            if (q_item.cmd == CMD_BYTES || q_item.cmd == CMD_PAGES) begin
              state <= S_USCAN;
            end else if (q_item.cmd == CMD_RELEASE) begin
              state <= S_RRD;
            end else begin
              res_st <= ST_NOTFOUND;
              state  <= S_OUT;
            end
          end
        end
        S_USCAN: begin
          if (!used_valid[uk]) begin
            us <= uk;
            if (cur.ovf) begin
              res_st <= ST_NOFIT;
              state  <= S_OUT;
            end else begin
              state <= S_FRD;
            end
          end else if (uk == U_LAST) begin
            res_st <= ST_FULL;
            state  <= S_OUT;
          end else begin
            uk <= uk + UW'(1);
          end
        end
        S_FRD: begin
          if (free_valid[fi]) begin
            state <= (cur.cmd == CMD_PAGES) ? S_FAL : S_FEV;
          end else if (fi == F_LAST) begin
            res_st <= ST_NOFIT;
            state  <= S_OUT;
          end else begin
            fi <= fi + FW'(1);
          end
        end
        S_FEV: begin
          if (rl >= cur.size) begin
            if (rl == cur.size) begin
              free_valid[fi] <= 1'b0;
            end
            used_valid[us] <= 1'b1;
            res_st   <= ST_OK;
            res_addr <= rb;
            state    <= S_OUT;
          end else if (fi == F_LAST) begin
            res_st <= ST_NOFIT;
            state  <= S_OUT;
          end else begin
            fi    <= fi + FW'(1);
            state <= S_FRD;
          end
        end
        S_FAL: begin
          al    <= ((33'(rb) + 33'(PAGE_BYTES - 1)) / 33'(PAGE_BYTES)) * 33'(PAGE_BYTES);
          endv  <= 33'(rb) + 33'(rl);
          state <= S_FFIT;
        end
        S_FFIT: begin
          ae <= fit_sum[32:0];
          if (fit) begin
            fj    <= '0;
            state <= (al[31:0] != rb) ? S_GSCAN : S_PWR;
          end else if (fi == F_LAST) begin
            res_st <= ST_NOFIT;
            state  <= S_OUT;
          end else begin
            fi    <= fi + FW'(1);
            state <= S_FRD;
          end
        end
        S_GSCAN: begin
          if (!free_valid[fj]) begin
            state <= S_GWR;
          end else if (fj == F_LAST) begin
            res_st <= ST_FULL;
            state  <= S_OUT;
          end else begin
            fj <= fj + FW'(1);
          end
        end
        S_GWR: begin
          free_valid[fj] <= 1'b1;
          state          <= S_PWR;
        end
        S_PWR: begin
          if (pw_len == 32'd0) begin
            free_valid[fi] <= 1'b0;
          end
          used_valid[us] <= 1'b1;
          res_st   <= ST_OK;
          res_addr <= al[31:0];
          state    <= S_OUT;
        end
        S_RRD: begin
          if (used_valid[uk]) begin
            state <= S_REV;
          end else if (uk == U_LAST) begin
            res_st <= ST_NOTFOUND;
            state  <= S_OUT;
          end else begin
            uk <= uk + UW'(1);
          end
        end
        S_REV: begin
          if (hit) begin
            fj    <= '0;
            state <= S_RFS;
          end else if (uk == U_LAST) begin
            res_st <= ST_NOTFOUND;
            state  <= S_OUT;
          end else begin
            uk    <= uk + UW'(1);
            state <= S_RRD;
          end
        end
        S_RFS: begin
          if (!free_valid[fj]) begin
            free_valid[fj] <= 1'b1;
            used_valid[uk] <= 1'b0;
            res_st <= ST_OK;
            state  <= S_OUT;
          end else if (fj == F_LAST) begin
            res_st <= ST_FULL;
            state  <= S_OUT;
          end else begin
            fj <= fj + FW'(1);
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_st;
            block_address <= (res_st == ST_OK) ? res_addr : 32'd0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/first_fit_extent_allocator_unit.sv
// First-fit extent allocator: requests are served by sequential scans of the used
// and free tables; one request at a time. Synchronous active-high reset, and any
// register write through the registered reinit strobe, restore the two initial free
// regions and clear the used table.
module first_fit_extent_allocator_unit #(
  parameter int FREE_DEPTH = ffea_pkg::DEF_FREE_DEPTH,
  parameter int USED_DEPTH = ffea_pkg::DEF_USED_DEPTH,
  parameter int PAGE_BYTES = ffea_pkg::DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] amount,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] block_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffea_pkg::*;

  region_t regions;
  logic    reinit;
  logic    q_valid;
  logic    q_pop;
  item_t   q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      regions.r0_base <= RST_R0_BASE;
      regions.r0_size <= RST_R0_SIZE;
      regions.r1_base <= RST_R1_BASE;
      regions.r1_size <= RST_R1_SIZE;
      reinit          <= 1'b0;
    end else begin
      reinit <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_R0_BASE: regions.r0_base <= cfg_data;
          REG_R0_SIZE: regions.r0_size <= cfg_data;
          REG_R1_BASE: regions.r1_base <= cfg_data;
          REG_R1_SIZE: regions.r1_size <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  ffea_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .amount   (amount),
    .address  (address),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  ffea_back #(
    .FREE_DEPTH(FREE_DEPTH),
    .USED_DEPTH(USED_DEPTH),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .reinit        (reinit),
    .regions       (regions),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .block_address (block_address)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_extent_allocator_unit: directed table, then random requests.
// Depends on ffea_pkg and the allocator RTL; predicts every response from its own table model.
module testbench;
  import ffea_pkg::*;

  localparam int NFREE = 64;
  localparam int NUSED = 256;
  localparam int PAGE = 4096;
  localparam int NRANDOM = 830;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] amount;
    logic [31:0] address;
    bit          fixed;
    logic [1:0]  st;
    logic [31:0] addr;
  } row_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] addr;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [31:0] amount = '0;
  logic [31:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [31:0] block_address;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] regs [4];
  logic [31:0] fb [NFREE];
  logic [31:0] fl [NFREE];
  bit fv [NFREE];
  logic [31:0] ub [NUSED];
  logic [31:0] ul [NUSED];
  bit uv [NUSED];
  logic [31:0] given [$];

  answer_t pending [$];
  int errors = 0;
  int answered = 0;
  int n_ok = 0;
  int n_full = 0;
  int n_nofit = 0;
  int n_nf = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  row_t rows [$];

  first_fit_extent_allocator_unit dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void reload_tables();
    for (int i = 0; i < NFREE; i++) begin
      fb[i] = '0; fl[i] = '0; fv[i] = 0;
    end
    for (int i = 0; i < NUSED; i++) begin
      ub[i] = '0; ul[i] = '0; uv[i] = 0;
    end
    fb[0] = regs[REG_R0_BASE]; fl[0] = regs[REG_R0_SIZE]; fv[0] = 1;
    fb[1] = regs[REG_R1_BASE]; fl[1] = regs[REG_R1_SIZE]; fv[1] = 1;
    given.delete();
  endfunction

  function automatic int open_free();
    for (int i = 0; i < NFREE; i++) if (!fv[i]) return i;
    return -1;
  endfunction

  function automatic int open_used();
    for (int i = 0; i < NUSED; i++) if (!uv[i]) return i;
    return -1;
  endfunction

  function automatic void note_used(int s, logic [31:0] b, logic [31:0] len);
    ub[s] = b; ul[s] = len; uv[s] = 1;
    if (len != 0) given.push_back(b);
  endfunction

  function automatic answer_t allocate_extent(logic [1:0] cmd, logic [31:0] amt,
                                              logic [31:0] a);
    answer_t r;
    int us;
    int gs;
    logic [63:0] sz;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] al;
    r.st = ST_NOFIT;
    r.addr = '0;
    if (cmd == CMD_RELEASE) begin
      r.st = ST_NOTFOUND;
      for (int i = 0; i < NUSED; i++) begin
        if (uv[i] && ub[i] <= a && {32'd0, ub[i]} + ul[i] > {32'd0, a}) begin
          gs = open_free();
          if (gs < 0) begin
            r.st = ST_FULL;
            return r;
          end
          fb[gs] = ub[i]; fl[gs] = ul[i]; fv[gs] = 1;
          ub[i] = '0; ul[i] = '0; uv[i] = 0;
          r.st = ST_OK;
          return r;
        end
      end
      return r;
    end
    if (cmd != CMD_BYTES && cmd != CMD_PAGES) begin
      r.st = ST_NOTFOUND;
      return r;
    end
    us = open_used();
    if (us < 0) begin
      r.st = ST_FULL;
      return r;
    end
    if (cmd == CMD_BYTES) begin
      sz = ({32'd0, amt} + 3) & ~64'd3;
      if (sz > 64'hFFFF_FFFF) return r;
      for (int i = 0; i < NFREE; i++) begin
        if (fv[i] && {32'd0, fl[i]} >= sz) begin
          r.addr = fb[i];
          fl[i] = fl[i] - sz[31:0];
          if (fl[i] == 0) fv[i] = 0;
          fb[i] = fb[i] + sz[31:0];
          note_used(us, r.addr, sz[31:0]);
          r.st = ST_OK;
          return r;
        end
      end
      return r;
    end
    sz = {32'd0, amt} * PAGE;
    if (sz > 64'hFFFF_FFFF) return r;
    for (int i = 0; i < NFREE; i++) begin
      if (!fv[i]) continue;
      b = {32'd0, fb[i]};
      e = b + fl[i];
      al = ((b + PAGE - 1) / PAGE) * PAGE;
      if (al > 64'hFFFF_FFFF || al + sz > e) continue;
      gs = -1;
      if (al != b) begin
        gs = open_free();
        if (gs < 0) begin
          r.st = ST_FULL;
          return r;
        end
      end
      fb[i] = al[31:0] + sz[31:0];
      fl[i] = 32'(e - (al + sz));
      if (fl[i] == 0) fv[i] = 0;
      if (gs >= 0) begin
        fb[gs] = b[31:0]; fl[gs] = al[31:0] - b[31:0]; fv[gs] = 1;
      end
      note_used(us, al[31:0], sz[31:0]);
      r.addr = al[31:0];
      r.st = ST_OK;
      return r;
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    regs[idx] = val;
    reload_tables();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send(logic [1:0] cmd, logic [31:0] amt, logic [31:0] a, bit fixed,
                      logic [1:0] st, logic [31:0] ad);
    answer_t r;
    int w;
    w = $urandom_range(0, 10);
    @(negedge clk);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1; command <= cmd; amount <= amt; address <= a;
    do @(posedge clk); while (!in_ready);
    r = allocate_extent(cmd, amt, a);
    if (fixed && (r.st != st || r.addr != ad)) begin
      $display("%0t: table row disagrees: expected %0d/%h, predicted %0d/%h",
               $time, st, ad, r.st, r.addr);
      errors++;
    end
    pending.push_back(r);
  endtask

  function automatic logic [31:0] pick_release();
    int k;
    if (given.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
    k = $urandom_range(0, given.size() - 1);
    pick_release = given[k] + $urandom_range(0, 3);
    given.delete(k);
  endfunction

  task automatic random_burst(int n, bit tiny);
    logic [1:0] c;
    logic [31:0] amt;
    for (int i = 0; i < n; i++) begin
      c = 2'($urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 2) == 0 ? 1 : 2));
      if ($urandom_range(0, 40) == 0) c = 2'd3;
      case ($urandom_range(0, 9))
        0: amt = $urandom;
        1: amt = 32'hFFFF_FFFF - $urandom_range(0, 7);
        2: amt = 32'h0010_0000 + $urandom_range(0, 3);
        default: amt = tiny ? $urandom_range(0, 40) : $urandom_range(0, 3000);
      endcase
      if (c == CMD_PAGES && $urandom_range(0, 5) != 0) amt = $urandom_range(0, 8);
      send(c, amt, c == CMD_RELEASE ? pick_release() : $urandom, 0, ST_OK, '0);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected response status %0d address %h", $time, status,
                 block_address);
        errors++;
      end else begin
        if (status !== pending[0].st) begin
          $display("%0t: status expected %0d actual %0d", $time, pending[0].st, status);
          errors++;
        end
        if (block_address !== pending[0].addr) begin
          $display("%0t: block_address expected %h actual %h", $time, pending[0].addr,
                   block_address);
          errors++;
        end
        case (pending[0].st)
          ST_OK: n_ok++;
          ST_FULL: n_full++;
          ST_NOFIT: n_nofit++;
          default: n_nf++;
        endcase
        void'(pending.pop_front());
        answered++;
      end
    end
  end

  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (out_ready && !(out_valid)) out_ready <= 1'b1;
      else if (out_valid && out_ready) begin
        w = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w != 0) begin
          out_ready <= 1'b0;
          repeat (w) @(negedge clk);
          if (!hold_off) out_ready <= 1'b1;
        end
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    regs[REG_R0_BASE] = RST_R0_BASE;
    regs[REG_R0_SIZE] = RST_R0_SIZE;
    regs[REG_R1_BASE] = RST_R1_BASE;
    regs[REG_R1_SIZE] = RST_R1_SIZE;
    reload_tables();
    rows = '{
      '{CMD_BYTES, 32'd1, 32'd0, 1, ST_OK, RST_R0_BASE},
      '{CMD_BYTES, 32'd0, 32'd0, 1, ST_OK, RST_R0_BASE + 4},
      '{CMD_BYTES, 32'hFFFF_FFFD, 32'd0, 1, ST_NOFIT, 32'd0},
      '{CMD_BYTES, 32'hFFFF_FFFC, 32'd0, 1, ST_NOFIT, 32'd0},
      '{CMD_PAGES, 32'd1, 32'd0, 1, ST_OK, RST_R0_BASE + PAGE},
      '{CMD_PAGES, 32'hFFFF_FFFF, 32'd0, 1, ST_NOFIT, 32'd0},
      '{CMD_PAGES, 32'h0010_0000, 32'd0, 1, ST_NOFIT, 32'd0},
      '{CMD_PAGES, 32'd0, 32'd0, 0, ST_OK, 32'd0},
      '{CMD_RELEASE, 32'd0, RST_R0_BASE + 3, 1, ST_OK, 32'd0},
      '{CMD_RELEASE, 32'd0, RST_R0_BASE, 1, ST_NOTFOUND, 32'd0},
      '{CMD_RELEASE, 32'd0, 32'hFFFF_FFFF, 1, ST_NOTFOUND, 32'd0},
      '{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_NOTFOUND, 32'd0},
      '{CMD_BYTES, 32'h0060_0000, 32'd0, 0, ST_OK, 32'd0},
      '{CMD_RELEASE, 32'd0, RST_R0_BASE + PAGE, 0, ST_OK, 32'd0},
      '{CMD_BYTES, 32'd5, 32'h5555_5555, 0, ST_OK, 32'd0},
      '{CMD_PAGES, 32'd3, 32'hAAAA_AAAA, 0, ST_OK, 32'd0}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send(rows[i].cmd, rows[i].amount, rows[i].address, rows[i].fixed,
                           rows[i].st, rows[i].addr);
    drain();
    // Regions near the top of the address space, unaligned, with an empty one.
    write_reg(REG_R0_BASE, 32'hFFFF_F001);
    write_reg(REG_R0_SIZE, 32'h0000_0FFF);
    write_reg(REG_R1_BASE, 32'hFFFF_0003);
    write_reg(REG_R1_SIZE, 32'h0000_0000);
    send(CMD_BYTES, 32'd0, 32'd0, 1, ST_OK, 32'hFFFF_F001);
    send(CMD_PAGES, 32'd1, 32'd0, 1, ST_NOFIT, 32'd0);
    send(CMD_BYTES, 32'h0000_0FFC, 32'd0, 1, ST_OK, 32'hFFFF_F001);
    random_burst(30, 1);
    drain();
    write_reg(REG_R1_BASE, 32'hFFFF_0003);
    write_reg(REG_R1_SIZE, 32'h0000_FFFD);
    write_reg(REG_R0_BASE, 32'h0000_0000);
    write_reg(REG_R0_SIZE, 32'hFFFF_FFFF);
    random_burst(200, 0);
    drain();
    // Small regions with tiny requests, meant to fill both tables.
    write_reg(REG_R0_BASE, 32'h0000_1234);
    write_reg(REG_R0_SIZE, 32'h0002_0000);
    write_reg(REG_R1_BASE, 32'h8000_0ABC);
    write_reg(REG_R1_SIZE, 32'h0004_0000);
    fork
      begin
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        random_burst(300, 1);
        @(negedge clk);
        in_valid <= 1'b0;
      end
    join
    drain();
    write_reg(REG_R0_SIZE, RST_R0_SIZE);
    write_reg(REG_R0_BASE, RST_R0_BASE);
    write_reg(REG_R1_SIZE, RST_R1_SIZE);
    write_reg(REG_R1_BASE, RST_R1_BASE);
    random_burst(NRANDOM - 530, 0);
    drain();
    $display("Covered %0d responses: %0d ok, %0d no fit, %0d table full, %0d not found.",
             answered, n_ok, n_nofit, n_full, n_nf);
    if (errors == 0 && pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### first_fit_extent_allocator_unit.f
sv/ffea_pkg.sv
sv/ffea_front.sv
sv/ffea_back.sv
sv/first_fit_extent_allocator_unit.sv
verif/testbench.sv
